// ----- sv/sha_pkg.sv -----
package sha_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned FillW   = 7;
  localparam logic [FillW-1:0] LengthPos = 7'd112;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef logic [WordW-1:0] word_t;

  // Work item passed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_DATA,
    OP_LAST
  } op_e;

  typedef struct packed {
    op_e        op;
    word_t      data;
    logic [3:0] count;
  } item_t;

  localparam word_t InitHash [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
    64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  localparam word_t RoundK [Rounds] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// ----- sv/sha_if.sv -----
interface sha_in_if;
  import sha_pkg::*;
  logic       valid;
  logic       ready;
  word_t      data_word;
  logic [3:0] byte_count;
  logic       last_word;
  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface sha_out_if;
  import sha_pkg::*;
  logic       valid;
  logic       ready;
  word_t      digest_word;
  logic [2:0] digest_index;
  logic       digest_last;
  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

// ----- sv/sha512_hash_engine_top.sv -----
// Items pass through the front queue, then each message byte and each pad byte
// is loaded in turn into the block buffer; every 128-byte block then runs
// schedule load, 80 rounds and hash update, and the digest goes out as 8
// digest transactions. A full 8-byte word is accepted and then loaded byte by
// byte, and every full block is compressed before the next byte is taken.
// Reset (asynchronous, active low) loads the initial hash and clears counters.
module sha512_hash_engine_top
  import sha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sha_in_if.sink   in_if,
  sha_out_if.source out_if
);

  logic  item_valid, item_ready;
  item_t item;

  sha_front u_front (
    .clk_i, .rst_ni, .in_if,
    .item_valid_o(item_valid), .item_ready_i(item_ready), .item_o(item)
  );

  sha_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i(item_valid), .item_ready_o(item_ready), .item_i(item), .out_if
  );

endmodule

// ----- sv/sha_front.sv -----
module sha_front
  import sha_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  sha_in_if.sink in_if,
  output logic  item_valid_o,
  input  logic  item_ready_i,
  output item_t item_o
);

  // Two-entry queue decoupling acceptance from the compression back end.
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [3:0] cnt_sat;
  logic       push, pop;

  assign cnt_sat      = (in_if.byte_count > 4'd8) ? 4'd8 : in_if.byte_count;
  assign in_if.ready  = (cnt_q != 2'd2);
  assign push         = in_if.valid && in_if.ready;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].op    <= in_if.last_word ? OP_LAST : OP_DATA;
      mem_q[wp_q].data  <= in_if.data_word;
      mem_q[wp_q].count <= cnt_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");

endmodule

// ----- sv/sha_back.sv -----
module sha_back
  import sha_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   item_valid_i,
  output logic   item_ready_o,
  input  item_t  item_i,
  sha_out_if.source out_if
);

  typedef enum logic [2:0] {
    S_IDLE, S_BYTES, S_PAD, S_SCHED, S_ROUND, S_ADD, S_EMIT
  } state_e;

  state_e     state_q;
  word_t      buf_q [16];
  word_t      hash_q [8];
  word_t      wr_q [8];
  logic [FillW-1:0] fill_q;
  logic [60:0] total_q;
  logic [6:0] round_q;
  logic [3:0] bidx_q;
  item_t      cur_q;
  logic       final_q;   // compression belongs to the closing pad block
  logic [2:0] oidx_q;
  logic       pad_first_q;

  logic [7:0] byte_v;
  word_t w_new, s0, s1, t1, t2, big0, big1, ch, maj, wt;

  assign item_ready_o = (state_q == S_IDLE);
  assign byte_v = cur_q.data[63 - 8*bidx_q[2:0] -: 8];

  // Message schedule: rolling 16-word window in the block buffer.
  assign s0 = rotr(buf_q[1], 1) ^ rotr(buf_q[1], 8) ^ (buf_q[1] >> 7);
  assign s1 = rotr(buf_q[14], 19) ^ rotr(buf_q[14], 61) ^ (buf_q[14] >> 6);
  assign w_new = s1 + buf_q[9] + s0 + buf_q[0];
  assign wt = buf_q[0];

  assign big1 = rotr(wr_q[4], 14) ^ rotr(wr_q[4], 18) ^ rotr(wr_q[4], 41);
  assign ch   = (wr_q[4] & wr_q[5]) | (~wr_q[4] & wr_q[6]);
  assign t1   = wr_q[7] + big1 + ch + RoundK[round_q] + wt;
  assign big0 = rotr(wr_q[0], 28) ^ rotr(wr_q[0], 34) ^ rotr(wr_q[0], 39);
  assign maj  = (wr_q[0] & wr_q[1]) | (wr_q[0] & wr_q[2]) | (wr_q[1] & wr_q[2]);
  assign t2   = big0 + maj;

  assign out_if.valid        = (state_q == S_EMIT);
  assign out_if.digest_word  = hash_q[oidx_q];
  assign out_if.digest_index = oidx_q;
  assign out_if.digest_last  = (oidx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
      for (int i = 0; i < 8; i++) wr_q[i] <= '0;
      for (int i = 0; i < 16; i++) buf_q[i] <= '0;
      cur_q   <= '0;
      fill_q  <= '0;
      total_q <= '0;
      round_q <= '0;
      bidx_q  <= '0;
      final_q <= 1'b0;
      oidx_q  <= '0;
      pad_first_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            cur_q  <= item_i;
            bidx_q <= '0;
            pad_first_q <= 1'b1;
            state_q <= (item_i.count != 4'd0) ? S_BYTES :
                       (item_i.op == OP_LAST) ? S_PAD : S_IDLE;
          end
        end
        // One byte a cycle into the block buffer; a full block starts compression.
        S_BYTES: begin
          buf_q[fill_q[6:3]][63 - 8*fill_q[2:0] -: 8] <= byte_v;
          total_q <= total_q + 61'd1;
          fill_q  <= fill_q + 1'b1;
          bidx_q  <= bidx_q + 4'd1;
          final_q <= 1'b0;
          if (fill_q == '1) begin
            state_q <= S_SCHED;
          end else if (bidx_q + 4'd1 == cur_q.count) begin
            state_q <= (cur_q.op == OP_LAST) ? S_PAD : S_IDLE;
          end
        end
        S_PAD: begin
          buf_q[fill_q[6:3]][63 - 8*fill_q[2:0] -: 8] <= pad_first_q ? PadByte : 8'h00;
          pad_first_q <= 1'b0;
          fill_q <= fill_q + 1'b1;
          if (fill_q == '1) begin
            final_q <= 1'b0;
            state_q <= S_SCHED;
          end else if (fill_q + 1'b1 == LengthPos) begin
            buf_q[14] <= '0;
            buf_q[15] <= {total_q, 3'b000};
            fill_q  <= '0;
            final_q <= 1'b1;
            state_q <= S_SCHED;
          end
        end
        S_SCHED: begin
          for (int i = 0; i < 8; i++) wr_q[i] <= hash_q[i];
          round_q <= '0;
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          wr_q[7] <= wr_q[6];
          wr_q[6] <= wr_q[5];
          wr_q[5] <= wr_q[4];
          wr_q[4] <= wr_q[3] + t1;
          wr_q[3] <= wr_q[2];
          wr_q[2] <= wr_q[1];
          wr_q[1] <= wr_q[0];
          wr_q[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) buf_q[i] <= buf_q[i+1];
          buf_q[15] <= w_new;
          round_q <= round_q + 7'd1;
          if (round_q == 7'(Rounds - 1)) state_q <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + wr_q[i];
          oidx_q <= '0;
          if (final_q) state_q <= S_EMIT;
          else if (cur_q.op == OP_LAST && (bidx_q == cur_q.count)) state_q <= S_PAD;
          else if (bidx_q != cur_q.count) state_q <= S_BYTES;
          else state_q <= S_IDLE;
        end
        S_EMIT: begin
          if (out_if.ready) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
              fill_q  <= '0;
              total_q <= '0;
              final_q <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_emit_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_EMIT) |-> $past(state_q) == S_ADD) else $error("emit without compress");
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROUND |-> round_q < 7'(Rounds)) else $error("round index overrun");
  a_fill_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_if.ready && oidx_q == 3'd7) |=> fill_q == '0)
    else $error("fill not cleared after digest");

endmodule

// ----- test/sha512_hash_engine_top_tb.sv -----
`timescale 1ns / 1ps

module sha512_hash_engine_top_tb;
  import sha_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    word_t      digest;
    logic [2:0] index;
    logic       last;
  } digest_t;

  // Scoreboard: owns a software SHA-512 and the queue of digest words due.
  class sha_scoreboard;
    word_t     hash_state [8];
    word_t     blk [16];
    int unsigned fill;
    logic [60:0] total_bytes;
    digest_t   pending [$];
    int unsigned errors;
    int unsigned digests_seen;

    function new();
      hash_state = InitHash;
      fill = 0;
      total_bytes = '0;
      errors = 0;
      digests_seen = 0;
    endfunction

    function word_t ror(word_t x, int unsigned n);
      return (x >> n) | (x << (64 - n));
    endfunction

    function void compress_block();
      word_t w [80];
      word_t a, b, c, d, e, f, g, h, t1, t2;
      for (int t = 0; t < 16; t++) w[t] = blk[t];
      for (int t = 16; t < 80; t++) begin
        w[t] = (ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
             + (ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int t = 0; t < 80; t++) begin
        t1 = h + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41)) + ((e & f) | (~e & g))
           + RoundK[t] + w[t];
        t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39)) + ((a & b) | (a & c) | (b & c));
        h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function void append_byte(logic [7:0] v, bit counted);
      int unsigned sh;
      sh = (7 - (fill % 8)) * 8;
      blk[fill / 8] = (blk[fill / 8] & ~(word_t'(8'hFF) << sh)) | (word_t'(v) << sh);
      if (counted) total_bytes = total_bytes + 1'b1;
      fill++;
      if (fill == 128) begin
        compress_block();
        fill = 0;
      end
    endfunction

    function void note_input(word_t data, logic [3:0] count, logic last);
      int unsigned n;
      word_t bits;
      n = (count > 8) ? 8 : count;
      for (int i = 0; i < n; i++) append_byte(data[(7 - i) * 8 +: 8], 1'b1);
      if (!last) return;
      bits = {total_bytes, 3'b000};
      append_byte(PadByte, 1'b0);
      while (fill != LengthPos) append_byte(8'h00, 1'b0);
      blk[14] = '0;
      blk[15] = bits;
      compress_block();
      for (int i = 0; i < 8; i++) pending.push_back('{hash_state[i], 3'(i), i == 7});
      hash_state = InitHash;
      fill = 0;
      total_bytes = '0;
    endfunction

    function void check_digest(word_t digest, logic [2:0] index, logic last);
      digest_t exp_d;
      digests_seen++;
      if (pending.size() == 0) begin
        $error("digest word with none expected: %h", digest);
        errors++;
        return;
      end
      exp_d = pending.pop_front();
      if (digest !== exp_d.digest) begin
        $error("digest_word expected %h actual %h", exp_d.digest, digest);
        errors++;
      end
      if (index !== exp_d.index) begin
        $error("digest_index expected %0d actual %0d", exp_d.index, index);
        errors++;
      end
      if (last !== exp_d.last) begin
        $error("digest_last expected %0d actual %0d", exp_d.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha512_hash_engine_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.sink)
  );

  sha_scoreboard sb;
  int unsigned cycles;
  int unsigned words_sent;
  int unsigned messages_sent;
  bit hold_off;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    cycles = 0;
    wait (cycles >= CycleLimit);
    $display("Timed out after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: accept at the rising edge, change ready at the falling edge.
  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (gap > 0) begin
        out_if.ready <= 1'b0;
        gap--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) gap = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_digest(out_if.digest_word, out_if.digest_index, out_if.digest_last);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction
  // with valid still high, so a following word can go out back to back.
  task automatic send_word(word_t data, logic [3:0] count, logic last, bit paced);
    int unsigned gap;
    gap = paced ? gap_len() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_word  <= data;
    in_if.byte_count <= count;
    in_if.last_word  <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(data, count, last);
    words_sent++;
    if (last) messages_sent++;
    @(negedge clk_i);
  endtask

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // One message: full words then a closing word of random size, content random.
  task automatic send_message(int unsigned full_words, bit paced);
    for (int i = 0; i < full_words; i++) send_word(rand_word(), 4'd8, 1'b0, paced);
    send_word(rand_word(), 4'($urandom_range(0, 8)), 1'b1, paced);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned n;
    sb = new();
    words_sent = 0;
    messages_sent = 0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_word = '0;
    in_if.byte_count = '0;
    in_if.last_word = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty message, extreme fields, oversize counts, short middle words.
    send_word('0, 4'd0, 1'b1, 1'b0);
    send_word('1, 4'd8, 1'b1, 1'b0);
    send_word(64'h6162630000000000, 4'd3, 1'b1, 1'b0);
    send_word('1, 4'd15, 1'b0, 1'b0);
    send_word(64'h0123456789ABCDEF, 4'd9, 1'b1, 1'b0);
    send_word(64'hFFFFFFFFFFFFFFFF, 4'd1, 1'b0, 1'b0);
    send_word(64'h5555555555555555, 4'd5, 1'b0, 1'b0);
    send_word(64'hAAAAAAAAAAAAAAAA, 4'd0, 1'b0, 1'b0);
    send_word(64'h8000000000000001, 4'd7, 1'b1, 1'b0);
    // Lengths around the block and length field boundaries.
    send_message(13, 1'b0);
    for (int i = 0; i < 14; i++) send_word(rand_word(), 4'd8, 1'b0, 1'b0);
    send_word('1, 4'd8, 1'b1, 1'b0);
    drain();

    // Pause on the sender until all digests are back, then stall the receiver
    // for a long stretch while words keep coming.
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_message(3, 1'b0);
        send_message(0, 1'b0);
        send_message(20, 1'b0);
      end
    join

    // Random messages, mostly short, a few spanning several blocks.
    while (words_sent < 340) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 17);
      send_message(n, 1'b1);
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d words in %0d messages, checked %0d digest words.",
             words_sent, messages_sent, sb.digests_seen);
    $display("Covered empty, partial and multi-block messages with stalls on both sides.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sha512_hash_engine_top.f -----
sv/sha_pkg.sv
sv/sha_if.sv
sv/sha_front.sv
sv/sha_back.sv
sv/sha512_hash_engine_top.sv
test/sha512_hash_engine_top_tb.sv
